/* rtl/cor_pkg.sv */
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants of the camera orientation rotator
// Fixed Q10 scale, datapath widths, channel payloads and register indexes.
// ----------------------------------------------------------------------------
package cor_pkg;

   // field widths and fixed-point scale (scale is a power of two)
   localparam int DATA_W      = 12;
   localparam int SCALE_SHIFT = 10;
   localparam int UNIT_SCALE  = 1 << SCALE_SHIFT;
   localparam int CFG_W       = 11;
   localparam int CSR_IDX_W   = 1;
   localparam int LIMIT_RESET = 724;

   // datapath widths
   localparam int PROD_W = 2 * DATA_W;          // state times step
   localparam int NUM_W  = PROD_W + 1;          // scaled state plus product
   localparam int ROT_W  = DATA_W + 2;          // rotated value, signed
   localparam int MAG_W  = ROT_W - 1;           // magnitude of rotated value
   localparam int RAD_W  = 2 * ROT_W;           // squared length, even width
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int DIVR_W = ROOT_W + 1;
   localparam int QUO_W  = SCALE_SHIFT + 1;
   localparam int CNT_W  = $clog2(ROOT_W);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_LIMIT_COS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_LIMIT_SIN = CSR_IDX_W'(1);

   typedef struct packed {
      logic signed [DATA_W-1:0] turn_step;
      logic signed [DATA_W-1:0] pitch_step;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] yaw_sine;
      logic signed [DATA_W-1:0] yaw_cosine;
      logic signed [DATA_W-1:0] tilt_sine;
      logic signed [DATA_W-1:0] tilt_cosine;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CFG_W-1:0]     wr_data;
   } csr_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sine;
      logic signed [DATA_W-1:0] cosine;
   } pair_type;

endpackage

/* rtl/cor_chan_if.sv */
// ----------------------------------------------------------------------------
// cor_chan_if: valid/ready channel
// Carries one payload of the given type; source drives valid and payload.
// ----------------------------------------------------------------------------
interface cor_chan_if #(parameter type payload_type = logic) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/cor_pair.sv */
// ----------------------------------------------------------------------------
// cor_pair: bit-serial rotate and renormalize of one sine/cosine pair
// Shift-add products, serial squares, two-bit-a-step root and serial divide.
// ----------------------------------------------------------------------------
module cor_pair (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  cor_pkg::pair_type                pair_in,
   input  logic signed [cor_pkg::DATA_W-1:0] step,
   output logic                             done,
   output cor_pkg::pair_type                pair_out
);
   import cor_pkg::*;

   typedef enum logic [2:0] {
      P_IDLE, P_MUL, P_SUM, P_ABS, P_SQR, P_ROOT, P_DIV, P_OUT
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   pair_type out_ff, out_in;

   pair_type old_ff, old_in;
   logic [DATA_W-1:0] mplr_ff, mplr_in;
   logic [PROD_W-1:0] mcd_c_ff, mcd_c_in, mcd_s_ff, mcd_s_in;
   logic [PROD_W-1:0] prod_c_ff, prod_c_in, prod_s_ff, prod_s_in;
   logic [ROT_W-1:0]  ns_ff, ns_in, nc_ff, nc_in;
   logic [MAG_W-1:0]  mag_s_ff, mag_s_in, mag_c_ff, mag_c_in;
   logic [MAG_W-1:0]  sqm_s_ff, sqm_s_in, sqm_c_ff, sqm_c_in;
   logic [RAD_W-1:0]  sqd_s_ff, sqd_s_in, sqd_c_ff, sqd_c_in;
   logic [RAD_W-1:0]  sq_ff, sq_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [DIVR_W-1:0] rs_ff, rs_in, rc_ff, rc_in;
   logic [QUO_W-1:0]  qs_ff, qs_in, qc_ff, qc_in;

   // combinational helpers
   logic              mul_last, sqr_last, root_last, div_last;
   logic [PROD_W-1:0] add_c, add_s;
   logic [NUM_W-1:0]  num_s, num_c, trunc_s, trunc_c;
   logic [ROT_W-1:0]  neg_ns, neg_nc;
   logic [MAG_W-1:0]  abs_s, abs_c;
   logic [RAD_W-1:0]  sq_add_s, sq_add_c;
   logic [REM_W-1:0]  rem_sh, trial;
   logic              root_ge;
   logic [DIVR_W-1:0] len, diff_s, diff_c;
   logic              ge_s, ge_c;
   logic [DATA_W-1:0] quo_s, quo_c;

   assign mul_last  = (cnt_ff == CNT_W'(DATA_W - 1));
   assign sqr_last  = (cnt_ff == CNT_W'(MAG_W - 1));
   assign root_last = (cnt_ff == CNT_W'(ROOT_W - 1));
   assign div_last  = (cnt_ff == CNT_W'(QUO_W - 1));

   // products: sign bit of the step has negative weight
   assign add_c = mplr_ff[0] ? mcd_c_ff : '0;
   assign add_s = mplr_ff[0] ? mcd_s_ff : '0;

   // scaled sine + product, cosine - product, then divide by scale toward zero
   assign num_s = {{(NUM_W-DATA_W-SCALE_SHIFT){old_ff.sine[DATA_W-1]}}, old_ff.sine,
                   {SCALE_SHIFT{1'b0}}}
                + {{(NUM_W-PROD_W){prod_c_ff[PROD_W-1]}}, prod_c_ff};
   assign num_c = {{(NUM_W-DATA_W-SCALE_SHIFT){old_ff.cosine[DATA_W-1]}}, old_ff.cosine,
                   {SCALE_SHIFT{1'b0}}}
                - {{(NUM_W-PROD_W){prod_s_ff[PROD_W-1]}}, prod_s_ff};
   assign trunc_s = num_s + (num_s[NUM_W-1] ? NUM_W'(UNIT_SCALE - 1) : '0);
   assign trunc_c = num_c + (num_c[NUM_W-1] ? NUM_W'(UNIT_SCALE - 1) : '0);

   assign neg_ns = '0 - ns_ff;
   assign neg_nc = '0 - nc_ff;
   assign abs_s  = ns_ff[ROT_W-1] ? neg_ns[MAG_W-1:0] : ns_ff[MAG_W-1:0];
   assign abs_c  = nc_ff[ROT_W-1] ? neg_nc[MAG_W-1:0] : nc_ff[MAG_W-1:0];

   assign sq_add_s = sqm_s_ff[0] ? sqd_s_ff : '0;
   assign sq_add_c = sqm_c_ff[0] ? sqd_c_ff : '0;

   // root: bring down two radicand bits a step
   assign rem_sh  = {rem_ff[REM_W-3:0], sq_ff[RAD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign root_ge = (rem_sh >= trial);

   // divide: remainder never exceeds the root, so quotient fits QUO_W bits
   assign len    = {1'b0, root_ff};
   assign ge_s   = (rs_ff >= len);
   assign ge_c   = (rc_ff >= len);
   assign diff_s = ge_s ? rs_ff - len : rs_ff;
   assign diff_c = ge_c ? rc_ff - len : rc_ff;

   assign quo_s = {{(DATA_W-QUO_W){1'b0}}, qs_ff};
   assign quo_c = {{(DATA_W-QUO_W){1'b0}}, qc_ff};

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      out_in    = out_ff;
      old_in    = old_ff;
      mplr_in   = mplr_ff;
      mcd_c_in  = mcd_c_ff;
      mcd_s_in  = mcd_s_ff;
      prod_c_in = prod_c_ff;
      prod_s_in = prod_s_ff;
      ns_in     = ns_ff;
      nc_in     = nc_ff;
      mag_s_in  = mag_s_ff;
      mag_c_in  = mag_c_ff;
      sqm_s_in  = sqm_s_ff;
      sqm_c_in  = sqm_c_ff;
      sqd_s_in  = sqd_s_ff;
      sqd_c_in  = sqd_c_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      rs_in     = rs_ff;
      rc_in     = rc_ff;
      qs_in     = qs_ff;
      qc_in     = qc_ff;

      unique case (phase_ff)
         P_IDLE: begin
            if (start) begin
               old_in    = pair_in;
               mplr_in   = step;
               mcd_c_in  = {{(PROD_W-DATA_W){pair_in.cosine[DATA_W-1]}}, pair_in.cosine};
               mcd_s_in  = {{(PROD_W-DATA_W){pair_in.sine[DATA_W-1]}}, pair_in.sine};
               prod_c_in = '0;
               prod_s_in = '0;
               cnt_in    = '0;
               phase_in  = P_MUL;
            end
         end
         P_MUL: begin
            prod_c_in = mul_last ? prod_c_ff - add_c : prod_c_ff + add_c;
            prod_s_in = mul_last ? prod_s_ff - add_s : prod_s_ff + add_s;
            mcd_c_in  = {mcd_c_ff[PROD_W-2:0], 1'b0};
            mcd_s_in  = {mcd_s_ff[PROD_W-2:0], 1'b0};
            mplr_in   = {1'b0, mplr_ff[DATA_W-1:1]};
            cnt_in    = mul_last ? '0 : cnt_ff + 1'b1;
            if (mul_last) begin
               phase_in = P_SUM;
            end
         end
         P_SUM: begin
            ns_in    = trunc_s[SCALE_SHIFT+ROT_W-1:SCALE_SHIFT];
            nc_in    = trunc_c[SCALE_SHIFT+ROT_W-1:SCALE_SHIFT];
            phase_in = P_ABS;
         end
         P_ABS: begin
            mag_s_in = abs_s;
            mag_c_in = abs_c;
            sqm_s_in = abs_s;
            sqm_c_in = abs_c;
            sqd_s_in = {{(RAD_W-MAG_W){1'b0}}, abs_s};
            sqd_c_in = {{(RAD_W-MAG_W){1'b0}}, abs_c};
            sq_in    = '0;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            phase_in = P_SQR;
         end
         P_SQR: begin
            sq_in    = sq_ff + sq_add_s + sq_add_c;
            sqd_s_in = {sqd_s_ff[RAD_W-2:0], 1'b0};
            sqd_c_in = {sqd_c_ff[RAD_W-2:0], 1'b0};
            sqm_s_in = {1'b0, sqm_s_ff[MAG_W-1:1]};
            sqm_c_in = {1'b0, sqm_c_ff[MAG_W-1:1]};
            cnt_in   = sqr_last ? '0 : cnt_ff + 1'b1;
            if (sqr_last) begin
               phase_in = P_ROOT;
            end
         end
         P_ROOT: begin
            rem_in  = root_ge ? rem_sh - trial : rem_sh;
            root_in = {root_ff[ROOT_W-2:0], root_ge};
            sq_in   = {sq_ff[RAD_W-3:0], 2'b00};
            cnt_in  = root_last ? '0 : cnt_ff + 1'b1;
            if (root_last) begin
               rs_in    = {{(DIVR_W-MAG_W){1'b0}}, mag_s_ff};
               rc_in    = {{(DIVR_W-MAG_W){1'b0}}, mag_c_ff};
               qs_in    = '0;
               qc_in    = '0;
               phase_in = P_DIV;
            end
         end
         P_DIV: begin
            rs_in  = {diff_s[DIVR_W-2:0], 1'b0};
            rc_in  = {diff_c[DIVR_W-2:0], 1'b0};
            qs_in  = {qs_ff[QUO_W-2:0], ge_s};
            qc_in  = {qc_ff[QUO_W-2:0], ge_c};
            cnt_in = div_last ? '0 : cnt_ff + 1'b1;
            if (div_last) begin
               phase_in = P_OUT;
            end
         end
         P_OUT: begin
            // zero length pair is kept as rotated (both halves are zero then)
            if (root_ff == '0) begin
               out_in.sine   = ns_ff[DATA_W-1:0];
               out_in.cosine = nc_ff[DATA_W-1:0];
            end else begin
               out_in.sine   = ns_ff[ROT_W-1] ? '0 - quo_s : quo_s;
               out_in.cosine = nc_ff[ROT_W-1] ? '0 - quo_c : quo_c;
            end
            done_in  = 1'b1;
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      old_ff    <= old_in;
      mplr_ff   <= mplr_in;
      mcd_c_ff  <= mcd_c_in;
      mcd_s_ff  <= mcd_s_in;
      prod_c_ff <= prod_c_in;
      prod_s_ff <= prod_s_in;
      ns_ff     <= ns_in;
      nc_ff     <= nc_in;
      mag_s_ff  <= mag_s_in;
      mag_c_ff  <= mag_c_in;
      sqm_s_ff  <= sqm_s_in;
      sqm_c_ff  <= sqm_c_in;
      sqd_s_ff  <= sqd_s_in;
      sqd_c_ff  <= sqd_c_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      rs_ff     <= rs_in;
      rc_ff     <= rc_in;
      qs_ff     <= qs_in;
      qc_ff     <= qc_in;
   end

   assign done     = done_ff;
   assign pair_out = out_ff;

endmodule

/* rtl/camera_orientation_rotate_top.sv */
// ----------------------------------------------------------------------------
// camera_orientation_rotate_top: yaw and pitch orientation rotator
// Turns two Q10 sine/cosine pairs by small-angle steps, renormalizes them
// and clamps the pitch pair to programmable limits.
//
//   channel  dir  payload                                        flow
//   req_ch   in   turn_step, pitch_step                          valid/ready
//   rsp_ch   out  yaw_sine, yaw_cosine, tilt_sine, tilt_cosine   valid/ready
//   csr_ch   in   reg_index, wr_data                             always ready
//
// One item at a time: the result is set by the bit-serial products, squares,
// root and divide in each pair unit (both pairs run in lockstep). An item with
// both steps zero skips the pair units and goes straight to the result.
// A waiting result sits in the output register; the next request is taken
// meanwhile and holds only at its end until that result is transferred.
// Reset is synchronous and restores the level orientation and default limits.
// ----------------------------------------------------------------------------
module camera_orientation_rotate_top (
   input logic        clock,
   input logic        reset,
   cor_chan_if.sink   req_ch,
   cor_chan_if.source rsp_ch,
   cor_chan_if.sink   csr_ch
);
   import cor_pkg::*;

   typedef enum logic [1:0] {T_IDLE, T_RUN, T_CLAMP, T_EMIT} top_state_type;

   top_state_type   state_ff, state_in;
   pair_type        yaw_ff, yaw_in, tilt_ff, tilt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [CFG_W-1:0] limit_cos_ff, limit_cos_in, limit_sin_ff, limit_sin_in;

   logic     req_xfer, csr_xfer, step_zero, run_start, rsp_free;
   logic     yaw_done, tilt_done;
   pair_type yaw_out, tilt_out, tilt_clamped;

   logic signed [DATA_W:0] ts, tc, lim_c, lim_s, lim_s_neg;

   assign req_ch.ready = (state_ff == T_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_xfer     = csr_ch.valid && csr_ch.ready;
   assign step_zero    = (req_ch.payload.turn_step == '0) && (req_ch.payload.pitch_step == '0);
   assign run_start    = req_xfer && !step_zero;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   cor_pair u_yaw (
      .clock    (clock),
      .reset    (reset),
      .start    (run_start),
      .pair_in  (yaw_ff),
      .step     (req_ch.payload.turn_step),
      .done     (yaw_done),
      .pair_out (yaw_out)
   );

   cor_pair u_tilt (
      .clock    (clock),
      .reset    (reset),
      .start    (run_start),
      .pair_in  (tilt_ff),
      .step     (req_ch.payload.pitch_step),
      .done     (tilt_done),
      .pair_out (tilt_out)
   );

   // pitch clamp, compared one bit wider so limits above 1023 stay positive
   assign ts        = {tilt_out.sine[DATA_W-1], tilt_out.sine};
   assign tc        = {tilt_out.cosine[DATA_W-1], tilt_out.cosine};
   assign lim_c     = {{(DATA_W+1-CFG_W){1'b0}}, limit_cos_ff};
   assign lim_s     = {{(DATA_W+1-CFG_W){1'b0}}, limit_sin_ff};
   assign lim_s_neg = '0 - lim_s;

   always_comb begin
      tilt_clamped = tilt_out;
      if (tc < lim_c) begin
         tilt_clamped.sine   = (ts < 0) ? lim_s_neg[DATA_W-1:0] : lim_s[DATA_W-1:0];
         tilt_clamped.cosine = lim_c[DATA_W-1:0];
      end else if (ts > lim_s) begin
         tilt_clamped.sine   = lim_s[DATA_W-1:0];
         tilt_clamped.cosine = lim_c[DATA_W-1:0];
      end else if (ts < lim_s_neg) begin
         tilt_clamped.sine   = lim_s_neg[DATA_W-1:0];
         tilt_clamped.cosine = lim_c[DATA_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      yaw_in       = yaw_ff;
      tilt_in      = tilt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         T_IDLE: begin
            if (req_xfer) begin
               state_in = step_zero ? T_EMIT : T_RUN;
            end
         end
         T_RUN: begin
            if (yaw_done && tilt_done) begin
               state_in = T_CLAMP;
            end
         end
         T_CLAMP: begin
            yaw_in   = yaw_out;
            tilt_in  = tilt_clamped;
            state_in = T_EMIT;
         end
         T_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.yaw_sine    = yaw_ff.sine;
               rsp_data_in.yaw_cosine  = yaw_ff.cosine;
               rsp_data_in.tilt_sine   = tilt_ff.sine;
               rsp_data_in.tilt_cosine = tilt_ff.cosine;
               state_in                = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         yaw_ff.sine    <= '0;
         yaw_ff.cosine  <= DATA_W'(UNIT_SCALE);
         tilt_ff.sine   <= '0;
         tilt_ff.cosine <= DATA_W'(UNIT_SCALE);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         yaw_ff       <= yaw_in;
         tilt_ff      <= tilt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      limit_cos_in = limit_cos_ff;
      limit_sin_in = limit_sin_ff;
      if (csr_xfer) begin
         unique case (csr_ch.payload.reg_index)
            REG_PITCH_LIMIT_COS: limit_cos_in = csr_ch.payload.wr_data;
            REG_PITCH_LIMIT_SIN: limit_sin_in = csr_ch.payload.wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_cos_ff <= CFG_W'(LIMIT_RESET);
         limit_sin_ff <= CFG_W'(LIMIT_RESET);
      end else begin
         limit_cos_ff <= limit_cos_in;
         limit_sin_ff <= limit_sin_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule
